// ----- rtl/rfp_pkg.sv -----
// Shared constants, codes and record types for the range flip / popcount tree.
// Used by the channel interfaces, the node RAM wrapper users and the top level.
`timescale 1ns / 1ps

package rfp_pkg;

  // Bit positions held by the tree, leaves of a perfect binary heap
  localparam int MAX_POSITIONS = 1024;
  localparam int TREE_LEVELS   = $clog2(MAX_POSITIONS);
  localparam int NODE_W        = TREE_LEVELS + 1;
  localparam int TREE_DEPTH    = 2 * MAX_POSITIONS;
  localparam int LVL_W         = $clog2(TREE_LEVELS + 1);
  localparam int OFS_W         = TREE_LEVELS;

  // Field widths fixed by the item format
  localparam int POS_W = 11;
  localparam int CNT_W = 11;
  localparam int OP_W  = 2;

  // Traversal stack
  localparam int STACK_DEPTH = 32;
  localparam int SP_W        = 5;

  localparam logic [POS_W-1:0] LEN_RESET = POS_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_FLIP  = 2'd0,
    OP_COUNT = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // One tree node as stored in the RAM
  typedef struct packed {
    logic             flip;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One pending visit: enter a node, or recombine its children
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [LVL_W-1:0]  level;
    logic              post;
  } frame_t;

endpackage

// ----- rtl/rfp_channels.sv -----
// Valid/ready channel interfaces for request and result items.
// Depends on rfp_pkg for field widths.
`timescale 1ns / 1ps

interface rfp_req_if import rfp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [POS_W-1:0] first_pos;
  logic [POS_W-1:0] last_pos;
  logic             bit_value;

  modport source(output valid, opcode, first_pos, last_pos, bit_value, input ready);
  modport sink(input valid, opcode, first_pos, last_pos, bit_value, output ready);
endinterface

interface rfp_res_if import rfp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] ones_count;
  logic             range_error;

  modport source(output valid, ones_count, range_error, input ready);
  modport sink(input valid, ones_count, range_error, output ready);
endinterface

// ----- rtl/rfp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/range_flip_popcount_tree_core.sv -----
// Top level: lazy segment tree of one-counts with range flip, range count, bit load.
// Depends on rfp_pkg, rfp_channels (rfp_req_if, rfp_res_if) and rfp_ram.
`timescale 1ns / 1ps
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+------------------------------------------------
//  req     | in  | valid/ready   | opcode, first_pos, last_pos, bit_value
//  res     | out | valid/ready   | ones_count, range_error
//  cfg     | in  | cfg_we        | cfg_wdata = length_in_use
//
//  After reset a clearing sweep writes every tree node with req.ready low.
//  An item walks the tree depth first over a single node RAM; each visited node is
//  popped and then read, a lazy flip pushed down adds a write to each child, and a
//  recombine reads both children before writing the sum. A wide flip visits up to about
//  40 nodes. A rejected flip or load ends in the idle state; a rejected count goes
//  through the done step. One item is worked on at a time.
//  A count result sits in an output register; a new item is taken while it waits.

module range_flip_popcount_tree_core import rfp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [POS_W-1:0] cfg_wdata,
  rfp_req_if.sink          req,
  rfp_res_if.source        res
);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_POP   = 9'b000000100,
    ST_NODE  = 9'b000001000,
    ST_PSHL  = 9'b000010000,
    ST_PSHR  = 9'b000100000,
    ST_SUML  = 9'b001000000,
    ST_SUMR  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [POS_W-1:0]  length_in_use;
  logic [NODE_W-1:0] clr_addr;
  opcode_t           op;
  logic              bit_val;
  logic [OFS_W-1:0]  x0, y0;
  logic [CNT_W-1:0]  sum;
  logic              err;
  logic [CNT_W-1:0]  lcount;
  frame_t            cur;
  frame_t            stack [STACK_DEPTH];
  logic [SP_W-1:0]   sp;

  // RAM port signals
  logic              we, re;
  logic [NODE_W-1:0] waddr, raddr;
  entry_t            wdata, rd;
  logic [ENTRY_W-1:0] rdata_raw;

  rfp_ram #(.WIDTH(ENTRY_W), .DEPTH(TREE_DEPTH)) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rd = entry_t'(rdata_raw);

  // Request checks
  opcode_t          req_op;
  logic [POS_W-1:0] len_eff;
  logic             rng_ok, ld_ok, go_walk;

  assign req_op  = opcode_t'(req.opcode);
  assign len_eff = (length_in_use > POS_W'(MAX_POSITIONS)) ? POS_W'(MAX_POSITIONS)
                                                           : length_in_use;
  assign rng_ok  = (req.first_pos != '0) && (req.first_pos <= req.last_pos) &&
                   (req.last_pos <= len_eff);
  assign ld_ok   = (req.first_pos != '0) && (req.first_pos <= len_eff);
  assign go_walk = ((req_op == OP_FLIP || req_op == OP_COUNT) && rng_ok) ||
                   (req_op == OP_LOAD && ld_ok);

  assign req.ready = (state == ST_IDLE);

  logic accept;
  assign accept = req.valid && req.ready;

  // Geometry of the current node
  logic [NODE_W-1:0] ofs_full, node_lc, node_rc;
  logic [CNT_W-1:0]  size, half;
  logic [OFS_W-1:0]  lo0, hi0, mid0;
  logic              covered, go_l, go_r;

  assign size     = CNT_W'(MAX_POSITIONS) >> cur.level;
  assign half     = size >> 1;
  assign ofs_full = cur.node & ~(NODE_W'(1) << cur.level);
  assign lo0      = OFS_W'(ofs_full << (LVL_W'(TREE_LEVELS) - cur.level));
  assign hi0      = lo0 + OFS_W'(size - CNT_W'(1));
  assign mid0     = lo0 + OFS_W'(half) - OFS_W'(1);
  assign covered  = (x0 <= lo0) && (hi0 <= y0);
  assign go_l     = (x0 <= mid0);
  assign go_r     = (y0 > mid0);
  assign node_lc  = {cur.node[NODE_W-2:0], 1'b0};
  assign node_rc  = {cur.node[NODE_W-2:0], 1'b1};

  // Frames to push after a partial visit: recombine (flip and load only), right child, left child
  frame_t     pf [3];
  logic [1:0] pn;
  logic       push_en;

  always_comb begin
    pf[0] = '0;
    pf[1] = '0;
    pf[2] = '0;
    pn    = 2'd0;
    if (op != OP_COUNT) begin
      pf[0] = '{node: cur.node, level: cur.level, post: 1'b1};
      pn    = 2'd1;
    end
    if (go_r) begin
      pf[pn] = '{node: node_rc, level: cur.level + LVL_W'(1), post: 1'b0};
      pn     = pn + 2'd1;
    end
    if (go_l) begin
      pf[pn] = '{node: node_lc, level: cur.level + LVL_W'(1), post: 1'b0};
      pn     = pn + 2'd1;
    end
  end

  frame_t top;
  assign top = stack[sp - SP_W'(1)];

  // Sequencer and RAM control
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = cur.node;
    wdata      = '0;
    re         = 1'b0;
    raddr      = top.node;
    push_en    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (go_walk) begin
            state_next = ST_POP;
          end else if (req_op == OP_COUNT) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_POP: begin
        if (sp == '0) begin
          state_next = (op == OP_COUNT) ? ST_DONE : ST_IDLE;
        end else begin
          re = 1'b1;
          if (top.post) begin
            raddr      = {top.node[NODE_W-2:0], 1'b0};
            state_next = ST_SUML;
          end else begin
            state_next = ST_NODE;
          end
        end
      end
      ST_NODE: begin
        if (covered) begin
          if (op == OP_FLIP) begin
            we    = 1'b1;
            wdata = '{flip: ~rd.flip, count: size - rd.count};
          end else if (op == OP_LOAD) begin
            we    = 1'b1;
            wdata = '{flip: 1'b0, count: CNT_W'(bit_val)};
          end
          state_next = ST_POP;
        end else if (rd.flip) begin
          // clear the mark here, hand it to both children
          we         = 1'b1;
          wdata      = '{flip: 1'b0, count: rd.count};
          re         = 1'b1;
          raddr      = node_lc;
          state_next = ST_PSHL;
        end else begin
          push_en    = 1'b1;
          state_next = ST_POP;
        end
      end
      ST_PSHL: begin
        we         = 1'b1;
        waddr      = node_lc;
        wdata      = '{flip: ~rd.flip, count: half - rd.count};
        re         = 1'b1;
        raddr      = node_rc;
        state_next = ST_PSHR;
      end
      ST_PSHR: begin
        we         = 1'b1;
        waddr      = node_rc;
        wdata      = '{flip: ~rd.flip, count: half - rd.count};
        push_en    = 1'b1;
        state_next = ST_POP;
      end
      ST_SUML: begin
        re         = 1'b1;
        raddr      = node_rc;
        state_next = ST_SUMR;
      end
      ST_SUMR: begin
        we         = 1'b1;
        wdata      = '{flip: 1'b0, count: lcount + rd.count};
        state_next = ST_POP;
      end
      ST_DONE: begin
        if (!res.valid || res.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      sp       <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + NODE_W'(1);
      end
      if (accept) begin
        sp <= go_walk ? SP_W'(1) : '0;
      end else if (state == ST_POP && sp != '0) begin
        sp <= sp - SP_W'(1);
      end else if (push_en) begin
        sp <= sp + SP_W'(pn);
      end
    end
  end

  // Item context, stack contents and accumulators
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= req_op;
      bit_val  <= req.bit_value;
      x0       <= OFS_W'(req.first_pos - POS_W'(1));
      y0       <= (req_op == OP_LOAD) ? OFS_W'(req.first_pos - POS_W'(1))
                                      : OFS_W'(req.last_pos - POS_W'(1));
      sum      <= '0;
      err      <= !go_walk;
      stack[0] <= '{node: NODE_W'(1), level: '0, post: 1'b0};
    end
    if (state == ST_POP && sp != '0) begin
      cur <= top;
    end
    if (state == ST_NODE && covered && op == OP_COUNT) begin
      sum <= sum + rd.count;
    end
    if (state == ST_SUML) begin
      lcount <= rd.count;
    end
    if (push_en) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pn) begin
          stack[SP_W'(sp + SP_W'(i))] <= pf[i];
        end
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= LEN_RESET;
    end else if (cfg_we) begin
      length_in_use <= cfg_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == ST_DONE && (!res.valid || res.ready)) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!res.valid || res.ready)) begin
      res.ones_count  <= err ? '0 : sum;
      res.range_error <= err;
    end
  end

  // Checks
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (we && re) |-> (waddr != raddr))
    else $error("node RAM read and write hit the same entry");

  a_stack_room: assert property (@(posedge clk) disable iff (rst)
    push_en |-> ({1'b0, sp} + (SP_W + 1)'(pn) < (SP_W + 1)'(STACK_DEPTH)))
    else $error("traversal stack overflow");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the done step");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.range_error) |-> (res.ones_count == '0))
    else $error("rejected count carries a nonzero value");

endmodule

// ----- dv/tb_range_flip_popcount_tree_core.sv -----
// Testbench for range_flip_popcount_tree_core: random and directed flip, count and load
// items checked against a flat bit-vector model. Depends on rfp_pkg and rfp_channels.
`timescale 1ns / 1ps

module tb_range_flip_popcount_tree_core;
  import rfp_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] ones_count;
    logic             range_error;
  } count_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [POS_W-1:0] cfg_wdata;

  rfp_req_if req();
  rfp_res_if res();

  range_flip_popcount_tree_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .res(res.source)
  );

  // Model state: the bit vector itself, positions 1..MAX_POSITIONS
  logic [MAX_POSITIONS:1] bit_store;
  logic [POS_W-1:0]       cur_length;
  count_res_t             pending_counts[$];
  int                     fail_count;
  int                     idle_cycles = 0;
  int                     hold_off = 0;
  bit                     hold_req = 1'b0;
  bit                     hold_ack = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Update the model with one item; queue a result for a count
  function automatic void apply_item(opcode_t op, logic [POS_W-1:0] x,
                                     logic [POS_W-1:0] y, logic v);
    int lim;
    int n;
    bit ok;
    count_res_t r;
    lim = (cur_length > MAX_POSITIONS) ? MAX_POSITIONS : int'(cur_length);
    ok = (x >= 1) && (x <= y) && (int'(y) <= lim);
    n = 0;
    case (op)
      OP_FLIP: begin
        if (ok) for (int i = x; i <= y; i++) bit_store[i] = ~bit_store[i];
      end
      OP_COUNT: begin
        if (ok) for (int i = x; i <= y; i++) n += bit_store[i];
        r.ones_count = ok ? CNT_W'(n) : '0;
        r.range_error = !ok;
        pending_counts.push_back(r);
      end
      OP_LOAD: begin
        if (x >= 1 && int'(x) <= lim) bit_store[x] = v;
      end
      default: ;
    endcase
  endfunction

  // Drive one item, wait for acceptance, then maybe idle
  task automatic send_item(opcode_t op, logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic v,
                           bit gaps = 1);
    int gap;
    req.valid <= 1'b1;
    req.opcode <= op;
    req.first_pos <= x;
    req.last_pos <= y;
    req.bit_value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    apply_item(op, x, y, v);
    gap = 0;
    if (gaps && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for all counts, then let the last tree walk finish before a write
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_length(logic [POS_W-1:0] len);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_length = len;
  endtask

  function automatic logic [POS_W-1:0] rand_pos(int lim);
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return 0;
    if (k == 1) return POS_W'(lim + $urandom_range(1, 3));
    if (k == 2) return POS_W'($urandom);
    return POS_W'($urandom_range(1, (lim < 1) ? 1 : lim));
  endfunction

  // Random mix; mostly valid ranges with random spans
  task automatic random_items(int count, bit gaps = 1);
    int lim;
    logic [POS_W-1:0] a;
    logic [POS_W-1:0] b;
    opcode_t op;
    for (int i = 0; i < count; i++) begin
      lim = (cur_length > MAX_POSITIONS) ? MAX_POSITIONS : int'(cur_length);
      a = rand_pos(lim);
      b = rand_pos(lim);
      if ($urandom_range(0, 9) != 0 && a > b) begin
        a ^= b; b ^= a; a ^= b;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: op = OP_FLIP;
        3, 4, 5, 6: op = OP_COUNT;
        9: op = OP_NONE;
        default: op = OP_LOAD;
      endcase
      send_item(op, a, b, 1'($urandom), gaps);
    end
  endtask

  task automatic test_directed();
    send_item(OP_COUNT, 1, 1024, 0);
    send_item(OP_LOAD, 1, 0, 1);
    send_item(OP_LOAD, 1024, 0, 1);
    send_item(OP_LOAD, 0, 0, 1);
    send_item(OP_LOAD, 1025, 0, 1);
    send_item(OP_COUNT, 1, 1024, 0);
    send_item(OP_FLIP, 1, 1024, 0);
    send_item(OP_COUNT, 1, 1024, 0);
    send_item(OP_FLIP, 512, 513, 0);
    send_item(OP_COUNT, 511, 514, 0);
    send_item(OP_FLIP, 0, 5, 0);
    send_item(OP_FLIP, 6, 5, 0);
    send_item(OP_FLIP, 1, 1025, 0);
    send_item(OP_COUNT, 0, 5, 0);
    send_item(OP_COUNT, 9, 8, 0);
    send_item(OP_COUNT, 1, 2047, 0);
    send_item(OP_NONE, 2047, 2047, 1);
    send_item(OP_COUNT, 1024, 1024, 0);
    send_item(OP_LOAD, 2047, 1, 0);
    send_item(OP_COUNT, 1, 1, 0);
  endtask

  // Shrink, hit the edges, grow back to check stored bits survive
  task automatic test_lengths();
    write_length(0);
    send_item(OP_FLIP, 1, 1, 0);
    send_item(OP_LOAD, 1, 0, 1);
    send_item(OP_COUNT, 1, 1, 0);
    random_items(30);
    write_length(1);
    send_item(OP_FLIP, 1, 1, 0);
    send_item(OP_COUNT, 1, 2, 0);
    random_items(100);
    write_length(37);
    random_items(300);
    write_length(2047);
    send_item(OP_COUNT, 1, 1024, 0);
    random_items(150);
    write_length(1024);
  endtask

  task automatic test_random();
    random_items(600);
  endtask

  // Receiver stalls while items keep coming, then back-to-back with no gaps
  task automatic test_backpressure();
    hold_req = ~hold_req;
    random_items(60, 0);
    random_items(100, 0);
  endtask

  // Result side: random stalls plus forced long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= 3000;
      res.ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
    end
  end

  // Check each count against the oldest expectation
  always @(posedge clk) begin
    count_res_t exp_r;
    if (!rst && res.valid && res.ready) begin
      if (pending_counts.size() == 0) begin
        $error("count result with none expected");
        fail_count++;
      end else begin
        exp_r = pending_counts.pop_front();
        if (res.ones_count !== exp_r.ones_count) begin
          $error("ones_count expected %0d got %0d", exp_r.ones_count, res.ones_count);
          fail_count++;
        end
        if (res.range_error !== exp_r.range_error) begin
          $error("range_error expected %0d got %0d", exp_r.range_error, res.range_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake; covers the clearing sweep and hold-off
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    bit_store = '0;
    cur_length = LEN_RESET;
    fail_count = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.opcode = OP_FLIP;
    req.first_pos = '0;
    req.last_pos = '0;
    req.bit_value = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_lengths();
    test_random();
    test_backpressure();
    drain();
    if (fail_count == 0 && pending_counts.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (pending_counts.size() != 0) $error("%0d counts never arrived", pending_counts.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule
